@@ src/dbt_pkg.sv @@
// ----------------------------------------------------------------------------
// dbt_pkg: shared definitions for the depth buffer test
// Sizes of the depth store, field widths, result codes, register indexes
// and the controller state type.
// ----------------------------------------------------------------------------
package dbt_pkg;

    // store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH_BITS = 24;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int COL_BITS   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // interface widths
    localparam int POS_BITS       = 16;
    localparam int DIM_BITS       = 9;
    localparam int CFG_INDEX_BITS = 8;
    localparam int COUNT_BITS     = 32;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic [ADDR_BITS-1:0]  STORE_LAST = ADDR_BITS'(STORE_SIZE - 1);
    localparam logic [DIM_BITS-1:0]   WIDTH_LIMIT  = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0]   HEIGHT_LIMIT = DIM_BITS'(MAX_HEIGHT);
    localparam logic [DIM_BITS-1:0]   DIM_RESET    = DIM_BITS'(256);

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    // result codes
    typedef enum logic [1:0] {
        OUT_DRAWN    = 2'd0,
        OUT_OCCLUDED = 2'd1,
        OUT_OUTSIDE  = 2'd2
    } outcome_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

endpackage

@@ src/depth_buffer_test.sv @@
// ----------------------------------------------------------------------------
// depth_buffer_test: z-buffer depth test, greater depth wins
// Reads the stored depth of each in-frame fragment, stores the new depth
// when it is strictly greater and keeps running counts of the decisions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) takes one fragment: pos_x, pos_y
//   (signed columns and rows) and a signed fixed-point depth.
//   Output channel (out_valid / out_ready) returns one item per fragment:
//   draw, outcome and the three running totals after that fragment.
//   Configuration channel (cfg_valid / cfg_ready) writes frame_width
//   (index 0) or frame_height (index 1); other indexes are ignored.
//   Order: the stored depth is read into a register, then the result is
//   registered once the output is free. No new fragment is taken until
//   the last is evaluated; the read precedes the entry's write-back.
//   Reset: counters clear at once, then a clearing pass writes the most
//   negative depth to every entry, one per cycle; in_ready stays low
//   during the pass, configuration writes are taken.
//   Stall: a result waiting on out_ready holds; a fragment already read
//   waits for the output register and no further fragment is accepted.
// ----------------------------------------------------------------------------
module depth_buffer_test (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // fragment channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [dbt_pkg::POS_BITS-1:0]  pos_x,
    input  logic signed [dbt_pkg::POS_BITS-1:0]  pos_y,
    input  logic signed [dbt_pkg::DEPTH_BITS-1:0] depth,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dbt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dbt_pkg::DIM_BITS-1:0]         cfg_data,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 draw,
    output logic [1:0]                           outcome,
    output logic [dbt_pkg::COUNT_BITS-1:0]       drawn_total,
    output logic [dbt_pkg::COUNT_BITS-1:0]       occluded_total,
    output logic [dbt_pkg::COUNT_BITS-1:0]       outside_total
);
    import dbt_pkg::*;

    // depth memory
    logic [DEPTH_BITS-1:0] mem [STORE_SIZE];
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [DEPTH_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_raddr;
    logic [DEPTH_BITS-1:0] rd_data_reg;

    state_t                state_reg, state_next;
    logic [ADDR_BITS-1:0]  clear_addr_reg, clear_addr_next;

    logic [DIM_BITS-1:0]   frame_width_reg, frame_height_reg;
    logic [DIM_BITS-1:0]   width_sat, height_sat;

    // fragment held between read and write-back
    logic                  inside_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [DEPTH_BITS-1:0] z_reg;

    logic [COUNT_BITS-1:0] drawn_count_reg, drawn_count_next;
    logic [COUNT_BITS-1:0] occluded_count_reg, occluded_count_next;
    logic [COUNT_BITS-1:0] outside_count_reg, outside_count_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  draw_reg, draw_next;
    outcome_t              outcome_reg, outcome_next;

    logic                  in_accept;
    logic                  x_ok, y_ok;
    logic [ADDR_BITS-1:0]  frag_addr;
    logic                  nearer;
    logic                  out_free;
    logic                  eval_done;

    // saturate the frame size to the store size
    assign width_sat  = (frame_width_reg > WIDTH_LIMIT) ? WIDTH_LIMIT : frame_width_reg;
    assign height_sat = (frame_height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : frame_height_reg;

    // bounds test and store address of the incoming fragment
    assign x_ok = !pos_x[POS_BITS-1] && ($unsigned(pos_x) < POS_BITS'(width_sat));
    assign y_ok = !pos_y[POS_BITS-1] && ($unsigned(pos_y) < POS_BITS'(height_sat));
    assign frag_addr = ADDR_BITS'(ADDR_BITS'(pos_y[ROW_BITS-1:0]) * ADDR_BITS'(MAX_WIDTH))
                     + ADDR_BITS'(pos_x[COL_BITS-1:0]);

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign nearer    = $signed(z_reg) > $signed(rd_data_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign eval_done = (state_reg == ST_EVAL) && out_free;

    // next state, memory control and result
    always_comb
    begin
        state_next          = state_reg;
        clear_addr_next     = clear_addr_reg;
        mem_we              = 1'b0;
        mem_waddr           = addr_reg;
        mem_wdata           = z_reg;
        mem_re              = 1'b0;
        mem_raddr           = frag_addr;
        drawn_count_next    = drawn_count_reg;
        occluded_count_next = occluded_count_reg;
        outside_count_next  = outside_count_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        draw_next           = draw_reg;
        outcome_next        = outcome_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = clear_addr_reg;
                mem_wdata       = DEPTH_MIN;
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == STORE_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mem_re     = x_ok && y_ok;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (!inside_reg)
                    begin
                        outside_count_next = outside_count_reg + 1'b1;
                        draw_next          = 1'b0;
                        outcome_next       = OUT_OUTSIDE;
                    end
                    else if (nearer)
                    begin
                        mem_we           = 1'b1;
                        drawn_count_next = drawn_count_reg + 1'b1;
                        draw_next        = 1'b1;
                        outcome_next     = OUT_DRAWN;
                    end
                    else
                    begin
                        occluded_count_next = occluded_count_reg + 1'b1;
                        draw_next           = 1'b0;
                        outcome_next        = OUT_OCCLUDED;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clear_addr_reg     <= '0;
            drawn_count_reg    <= '0;
            occluded_count_reg <= '0;
            outside_count_reg  <= '0;
            out_valid_reg      <= 1'b0;
            frame_width_reg    <= DIM_RESET;
            frame_height_reg   <= DIM_RESET;
        end
        else
        begin
            state_reg          <= state_next;
            clear_addr_reg     <= clear_addr_next;
            drawn_count_reg    <= drawn_count_next;
            occluded_count_reg <= occluded_count_next;
            outside_count_reg  <= outside_count_next;
            out_valid_reg      <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                begin
                    frame_width_reg <= cfg_data;
                end
                else if (cfg_index == REG_FRAME_HEIGHT)
                begin
                    frame_height_reg <= cfg_data;
                end
            end
        end
    end

    // hold the accepted fragment and the result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            inside_reg <= x_ok && y_ok;
            addr_reg   <= frag_addr;
            z_reg      <= depth;
        end
        draw_reg    <= draw_next;
        outcome_reg <= outcome_next;
    end

    // depth memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign draw           = draw_reg;
    assign outcome        = outcome_reg;
    assign drawn_total    = drawn_count_reg;
    assign occluded_total = occluded_count_reg;
    assign outside_total  = outside_count_reg;

`ifndef SYNTHESIS
    // one fragment in flight: no accept straight after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !in_ready)
        else $error("fragment accepted while another is in flight");

    // totals stay put while a result waits
    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(drawn_total) && $stable(occluded_total)
                                       && $stable(outside_total)))
        else $error("totals changed under a waiting result");

    // draw flag agrees with the outcome code
    a_draw_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (draw == (outcome == OUT_DRAWN)))
        else $error("draw flag and outcome disagree");

    // the store is written only during the clearing pass or a draw
    a_write_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || (eval_done && inside_reg && nearer)))
        else $error("unexpected depth store write");
`endif

endmodule
